// ===== sv/fs_trk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fs_trk_pkg
// Shared constants, operation codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package fs_trk_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_BITS_DEF = 104;

    localparam int KEY_W     = 104;
    localparam int KEY_LO_W  = 64;
    localparam int KEY_HI_W  = 40;
    localparam int OP_W      = 2;
    localparam int LEN_W     = 16;
    localparam int TIME_W    = 64;
    localparam int CNT_W     = 7;
    localparam int CTR_W     = 64;

    localparam logic [OP_W-1:0] OP_TRACK  = 2'd0;
    localparam logic [OP_W-1:0] OP_SWEEP  = 2'd1;
    localparam logic [OP_W-1:0] OP_EXPORT = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic load;       // latch the input item, restart the scan
        logic rd;         // read all slot memories at the scan address
        logic inc;        // advance the scan address
        logic capt_hit;   // remember the hit slot and its counters
        logic capt_free;  // remember the lowest free slot
        logic clr_valid;  // free the scanned slot
        logic capt_pend;  // hold the scanned slot as next export record
        logic fin;        // finish the item: write back and emit last result
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic hit;
        logic slot_free;
        logic expire;
        logic elig;
        logic scan_last;
        logic out_free;
        logic at_limit;
        logic pend_valid;
        logic free_found;
    } t_stat;

endpackage
`default_nettype wire

// ===== sv/fs_trk_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fs_trk_datapath
// Slot memories, valid bits, scan address, counters and the output register.
// ----------------------------------------------------------------------------
module fs_trk_datapath #(
    parameter int CAPACITY = fs_trk_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = fs_trk_pkg::KEY_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire fs_trk_pkg::t_cmd                 i_cmd,
    output fs_trk_pkg::t_stat                     o_stat,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [fs_trk_pkg::TIME_W-1:0]    i_cfg_wr_data,
    input  wire logic [fs_trk_pkg::OP_W-1:0]      i_operation,
    input  wire logic [fs_trk_pkg::KEY_LO_W-1:0]  i_key_low,
    input  wire logic [fs_trk_pkg::KEY_HI_W-1:0]  i_key_high,
    input  wire logic [fs_trk_pkg::LEN_W-1:0]     i_packet_length,
    input  wire logic [fs_trk_pkg::TIME_W-1:0]    i_now_time,
    input  wire logic [fs_trk_pkg::CNT_W-1:0]     i_export_limit,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic                                  o_status,
    output logic                                  o_is_new,
    output logic [fs_trk_pkg::CNT_W-1:0]          o_count,
    output logic                                  o_record_valid,
    output logic [fs_trk_pkg::KEY_LO_W-1:0]       o_out_key_low,
    output logic [fs_trk_pkg::KEY_HI_W-1:0]       o_out_key_high,
    output logic [fs_trk_pkg::TIME_W-1:0]         o_out_last_seen,
    output logic [fs_trk_pkg::CTR_W-1:0]          o_out_packets,
    output logic [fs_trk_pkg::CTR_W-1:0]          o_out_bytes,
    output logic                                  o_last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int TW = fs_trk_pkg::TIME_W;
    localparam int CW = fs_trk_pkg::CTR_W;
    localparam int NW = fs_trk_pkg::CNT_W;

    // slot storage
    logic [KEY_BITS-1:0] mem_key  [CAPACITY];
    logic [TW-1:0]       mem_seen [CAPACITY];
    logic [CW-1:0]       mem_pkt  [CAPACITY];
    logic [CW-1:0]       mem_byt  [CAPACITY];
    logic [CAPACITY-1:0] r_valid;

    // latched item
    logic [fs_trk_pkg::OP_W-1:0]  r_op;
    logic [KEY_BITS-1:0]          r_key;
    logic [fs_trk_pkg::LEN_W-1:0] r_len;
    logic [TW-1:0]                r_now;
    logic [NW-1:0]                r_limit;
    logic [TW-1:0]                r_timeout;

    // scan state
    logic [AW-1:0]       r_addr;
    logic [KEY_BITS-1:0] r_rd_key;
    logic [TW-1:0]       r_rd_seen;
    logic [CW-1:0]       r_rd_pkt;
    logic [CW-1:0]       r_rd_byt;
    logic                r_hit;
    logic [AW-1:0]       r_hit_addr;
    logic [CW-1:0]       r_hpkt;
    logic [CW-1:0]       r_hbyt;
    logic                r_free_found;
    logic [AW-1:0]       r_free_addr;
    logic [NW-1:0]       r_freed;
    logic [NW-1:0]       r_n;

    // pending export record
    logic                r_pend_valid;
    logic [NW-1:0]       r_pend_cnt;
    logic [KEY_BITS-1:0] r_pend_key;
    logic [TW-1:0]       r_pend_seen;
    logic [CW-1:0]       r_pend_pkt;
    logic [CW-1:0]       r_pend_byt;

    // output register
    logic                r_ovalid;
    logic                r_status, n_status;
    logic                r_is_new, n_is_new;
    logic [NW-1:0]       r_count, n_count;
    logic                r_recv, n_recv;
    logic [fs_trk_pkg::KEY_W-1:0] r_okey, n_okey;
    logic [TW-1:0]       r_oseen, n_oseen;
    logic [CW-1:0]       r_opkt, n_opkt;
    logic [CW-1:0]       r_obyt, n_obyt;
    logic                r_last, n_last;

    logic [fs_trk_pkg::KEY_W-1:0] w_key_full;
    logic                w_vcur;
    logic [TW-1:0]       w_age;
    logic                w_old;
    logic                w_seen_nz;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic                w_oload;

    assign w_key_full = {i_key_high, i_key_low};
    assign w_vcur     = r_valid[r_addr];
    assign w_age      = r_now - r_rd_seen;
    assign w_old      = (r_timeout != '0) && (w_age > r_timeout);
    assign w_seen_nz  = (r_rd_seen != '0);

    always_comb begin
        o_stat            = '0;
        o_stat.op         = r_op;
        o_stat.hit        = w_vcur && (r_rd_key == r_key);
        o_stat.slot_free  = !w_vcur;
        o_stat.expire     = w_vcur && w_seen_nz && w_old;
        o_stat.elig       = w_vcur && w_seen_nz && !w_old;
        o_stat.scan_last  = (r_addr == AW'(CAPACITY - 1));
        o_stat.out_free   = !r_ovalid || i_ready;
        o_stat.at_limit   = (r_n == r_limit);
        o_stat.pend_valid = r_pend_valid;
        o_stat.free_found = r_free_found;
    end

    // track write-back
    assign w_we    = i_cmd.fin && (r_op == fs_trk_pkg::OP_TRACK) && (r_hit || r_free_found);
    assign w_waddr = r_hit ? r_hit_addr : r_free_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_key  <= mem_key[r_addr];
            r_rd_seen <= mem_seen[r_addr];
            r_rd_pkt  <= mem_pkt[r_addr];
            r_rd_byt  <= mem_byt[r_addr];
        end
        if (w_we) begin
            mem_key[w_waddr]  <= r_key;
            mem_seen[w_waddr] <= r_now;
            mem_pkt[w_waddr]  <= r_hit ? (r_hpkt + CW'(1)) : CW'(1);
            mem_byt[w_waddr]  <= r_hit ? (r_hbyt + CW'(r_len)) : CW'(r_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_timeout    <= '0;
            r_op         <= fs_trk_pkg::OP_TRACK;
            r_addr       <= '0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_freed      <= '0;
            r_n          <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_timeout <= i_cfg_wr_data;
            end
            if (i_cmd.load) begin
                r_op         <= i_operation;
                r_addr       <= '0;
                r_hit        <= 1'b0;
                r_free_found <= 1'b0;
                r_freed      <= '0;
                r_n          <= '0;
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.inc) begin
                r_addr <= r_addr + AW'(1);
            end
            if (i_cmd.capt_hit) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.capt_free) begin
                r_free_found <= 1'b1;
            end
            if (i_cmd.clr_valid) begin
                r_valid[r_addr] <= 1'b0;
                r_freed         <= r_freed + NW'(1);
            end
            if (i_cmd.capt_pend) begin
                r_pend_valid <= 1'b1;
                r_n          <= r_n + NW'(1);
            end
            if (w_we && !r_hit) begin
                r_valid[r_free_addr] <= 1'b1;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key   <= w_key_full[KEY_BITS-1:0];
            r_len   <= i_packet_length;
            r_now   <= i_now_time;
            r_limit <= i_export_limit;
        end
        if (i_cmd.capt_hit) begin
            r_hit_addr <= r_addr;
            r_hpkt     <= r_rd_pkt;
            r_hbyt     <= r_rd_byt;
        end
        if (i_cmd.capt_free) begin
            r_free_addr <= r_addr;
        end
        if (i_cmd.capt_pend) begin
            r_pend_cnt  <= r_n + NW'(1);
            r_pend_key  <= r_rd_key;
            r_pend_seen <= r_rd_seen;
            r_pend_pkt  <= r_rd_pkt;
            r_pend_byt  <= r_rd_byt;
        end
    end

    // result selection
    assign w_oload = i_cmd.fin || (i_cmd.capt_pend && r_pend_valid);

    always_comb begin
        n_status = 1'b0;
        n_is_new = 1'b0;
        n_count  = '0;
        n_recv   = 1'b0;
        n_okey   = '0;
        n_oseen  = '0;
        n_opkt   = '0;
        n_obyt   = '0;
        n_last   = 1'b1;
        if (i_cmd.capt_pend || (r_op == fs_trk_pkg::OP_EXPORT && r_pend_valid)) begin
            n_recv                 = 1'b1;
            n_count                = r_pend_cnt;
            n_okey[KEY_BITS-1:0]   = r_pend_key;
            n_oseen                = r_pend_seen;
            n_opkt                 = r_pend_pkt;
            n_obyt                 = r_pend_byt;
            n_last                 = !i_cmd.capt_pend;
        end else begin
            case (r_op)
                fs_trk_pkg::OP_TRACK: begin
                    n_status = !r_hit && !r_free_found;
                    n_is_new = !r_hit && r_free_found;
                end
                fs_trk_pkg::OP_SWEEP: begin
                    n_count = r_freed;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            if (w_oload) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_oload) begin
            r_status <= n_status;
            r_is_new <= n_is_new;
            r_count  <= n_count;
            r_recv   <= n_recv;
            r_okey   <= n_okey;
            r_oseen  <= n_oseen;
            r_opkt   <= n_opkt;
            r_obyt   <= n_obyt;
            r_last   <= n_last;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_status        = r_status;
    assign o_is_new        = r_is_new;
    assign o_count         = r_count;
    assign o_record_valid  = r_recv;
    assign o_out_key_low   = r_okey[fs_trk_pkg::KEY_LO_W-1:0];
    assign o_out_key_high  = r_okey[fs_trk_pkg::KEY_W-1:fs_trk_pkg::KEY_LO_W];
    assign o_out_last_seen = r_oseen;
    assign o_out_packets   = r_opkt;
    assign o_out_bytes     = r_obyt;
    assign o_last          = r_last;

endmodule
`default_nettype wire

// ===== sv/fs_trk_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fs_trk_ctrl
// Sequencer: accepts an item, walks the slots read/evaluate (an unused code skips the walk), then finishes.
// ----------------------------------------------------------------------------
module fs_trk_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [fs_trk_pkg::OP_W-1:0] i_operation,
    input  wire fs_trk_pkg::t_stat           i_stat,
    output fs_trk_pkg::t_cmd                 o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       w_next;   // move on to the next slot

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        w_next  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_operation == fs_trk_pkg::OP_UNUSED) ? S_FIN : S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                case (i_stat.op)
                    fs_trk_pkg::OP_TRACK: begin
                        if (i_stat.hit) begin
                            o_cmd.capt_hit = 1'b1;
                            n_state = S_FIN;
                        end else begin
                            o_cmd.capt_free = i_stat.slot_free && !i_stat.free_found;
                            w_next = 1'b1;
                        end
                    end
                    fs_trk_pkg::OP_SWEEP: begin
                        o_cmd.clr_valid = i_stat.expire;
                        w_next = 1'b1;
                    end
                    fs_trk_pkg::OP_EXPORT: begin
                        if (i_stat.elig) begin
                            if (i_stat.at_limit) begin
                                n_state = S_FIN;
                            end else if (!i_stat.pend_valid || i_stat.out_free) begin
                                o_cmd.capt_pend = 1'b1;
                                w_next = 1'b1;
                            end
                        end else begin
                            w_next = 1'b1;
                        end
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
                if (w_next) begin
                    if (i_stat.scan_last) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.inc = 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== sv/flow_session_tracker_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flow_session_tracker_top
// Fully associative flow table with idle timeout, track / sweep / export.
// ----------------------------------------------------------------------------
// One item is handled at a time. Track, sweep and export walk the slot
// memories through a single read port, each slot read and then evaluated;
// a track stops at the first hit, an export stops at its limit and may wait
// while the result side stalls, and an unused operation code goes straight
// to finish without a scan.
// Results leave through an output register, so the next item is accepted
// while the last result still waits. Export records are held one deep so
// the final one can carry last; an export that finds nothing returns one
// empty result. Slot contents are written only when a track creates or
// refreshes a session; the idle timeout is written through i_cfg_wr_en.
// ----------------------------------------------------------------------------
module flow_session_tracker_top #(
    parameter int CAPACITY = fs_trk_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = fs_trk_pkg::KEY_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [fs_trk_pkg::TIME_W-1:0]    i_cfg_wr_data,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [fs_trk_pkg::OP_W-1:0]      i_operation,
    input  wire logic [fs_trk_pkg::KEY_LO_W-1:0]  i_key_low,
    input  wire logic [fs_trk_pkg::KEY_HI_W-1:0]  i_key_high,
    input  wire logic [fs_trk_pkg::LEN_W-1:0]     i_packet_length,
    input  wire logic [fs_trk_pkg::TIME_W-1:0]    i_now_time,
    input  wire logic [fs_trk_pkg::CNT_W-1:0]     i_export_limit,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic                                  o_status,
    output logic                                  o_is_new,
    output logic [fs_trk_pkg::CNT_W-1:0]          o_count,
    output logic                                  o_record_valid,
    output logic [fs_trk_pkg::KEY_LO_W-1:0]       o_out_key_low,
    output logic [fs_trk_pkg::KEY_HI_W-1:0]       o_out_key_high,
    output logic [fs_trk_pkg::TIME_W-1:0]         o_out_last_seen,
    output logic [fs_trk_pkg::CTR_W-1:0]          o_out_packets,
    output logic [fs_trk_pkg::CTR_W-1:0]          o_out_bytes,
    output logic                                  o_last
);

    // command / status between sequencer and datapath
    fs_trk_pkg::t_cmd  w_cmd;
    fs_trk_pkg::t_stat w_stat;

    fs_trk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    fs_trk_datapath #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_operation     (i_operation),
        .i_key_low       (i_key_low),
        .i_key_high      (i_key_high),
        .i_packet_length (i_packet_length),
        .i_now_time      (i_now_time),
        .i_export_limit  (i_export_limit),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_is_new        (o_is_new),
        .o_count         (o_count),
        .o_record_valid  (o_record_valid),
        .o_out_key_low   (o_out_key_low),
        .o_out_key_high  (o_out_key_high),
        .o_out_last_seen (o_out_last_seen),
        .o_out_packets   (o_out_packets),
        .o_out_bytes     (o_out_bytes),
        .o_last          (o_last)
    );

endmodule
`default_nettype wire

// ===== sv/fs_trk_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fs_trk_checker
// Port-level checks on the tracker, bound to the top level.
// ----------------------------------------------------------------------------
module fs_trk_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_valid,
    input wire logic                             o_ready,
    input wire logic                             o_valid,
    input wire logic                             i_ready,
    input wire logic                             o_status,
    input wire logic                             o_is_new,
    input wire logic [fs_trk_pkg::CNT_W-1:0]     o_count,
    input wire logic                             o_record_valid,
    input wire logic [fs_trk_pkg::KEY_LO_W-1:0]  o_out_key_low,
    input wire logic [fs_trk_pkg::TIME_W-1:0]    o_out_last_seen,
    input wire logic [fs_trk_pkg::CTR_W-1:0]     o_out_packets,
    input wire logic [fs_trk_pkg::CTR_W-1:0]     o_out_bytes,
    input wire logic                             o_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_count) && $stable(o_last)
            && $stable(o_out_packets)))
        else $error("result changed while stalled");

    // one item at a time: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second item taken while busy");

    a_empty_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_record_valid) |-> (o_out_packets == '0 && o_out_bytes == '0
            && o_out_last_seen == '0 && o_out_key_low == '0))
        else $error("non-record result carries session data");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (!o_is_new && o_last && !o_record_valid))
        else $error("full status with inconsistent fields");

    a_rec_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_record_valid) |-> (o_count != '0 && o_count <= 7'd64 && !o_status))
        else $error("export record count out of range");

endmodule

bind flow_session_tracker_top fs_trk_checker u_fs_trk_checker (.*);
`default_nettype wire

// ===== tb/flow_session_tracker_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_session_tracker_top_tb
// Self-checking bench: drives track, sweep and export items with random gaps
// and back-pressure, predicts every result from a model of the flow table,
// and compares each result field by field.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic        status;
    logic        is_new;
    logic [6:0]  count;
    logic        record_valid;
    logic [63:0] key_low;
    logic [39:0] key_high;
    logic [63:0] last_seen;
    logic [63:0] packets;
    logic [63:0] bytes_seen;
    logic        last;
} flow_result_t;

class flow_table_scoreboard;
    bit          live[64];
    logic [63:0] key_lo[64];
    logic [39:0] key_hi[64];
    logic [63:0] seen[64];
    logic [63:0] pkts[64];
    logic [63:0] byts[64];
    logic [63:0] timeout;
    flow_result_t pending[$];
    int errors;
    int results_seen;
    int full_hits;
    int exported;

    function void clear_table();
        foreach (live[s]) live[s] = 0;
        timeout = '0;
    endfunction

    function bit is_idle(int s, logic [63:0] now);
        return timeout != 0 && (now - seen[s]) > timeout;
    endfunction

    // Work out the results of one accepted item and queue them.
    function void note_item(logic [1:0] op, logic [63:0] klo, logic [39:0] khi,
                            logic [15:0] len, logic [63:0] now, logic [6:0] lim);
        flow_result_t r;
        int hit, free_slot, n;
        r = '0;
        r.last = 1;
        hit = -1;
        free_slot = -1;
        n = 0;
        case (op)
            fs_trk_pkg::OP_TRACK: begin
                for (int s = 0; s < 64; s++) begin
                    if (live[s]) begin
                        if (hit < 0 && key_lo[s] == klo && key_hi[s] == khi) hit = s;
                    end else if (free_slot < 0) begin
                        free_slot = s;
                    end
                end
                if (hit >= 0) begin
                    seen[hit] = now;
                    pkts[hit] += 1;
                    byts[hit] += len;
                end else if (free_slot >= 0) begin
                    live[free_slot] = 1;
                    key_lo[free_slot] = klo;
                    key_hi[free_slot] = khi;
                    seen[free_slot] = now;
                    pkts[free_slot] = 1;
                    byts[free_slot] = len;
                    r.is_new = 1;
                end else begin
                    r.status = 1;
                    full_hits++;
                end
                pending.push_back(r);
            end
            fs_trk_pkg::OP_SWEEP: begin
                for (int s = 0; s < 64; s++)
                    if (live[s] && seen[s] != 0 && is_idle(s, now)) begin
                        live[s] = 0;
                        n++;
                    end
                r.count = 7'(n);
                pending.push_back(r);
            end
            fs_trk_pkg::OP_EXPORT: begin
                for (int s = 0; s < 64; s++) begin
                    if (!live[s] || seen[s] == 0 || is_idle(s, now)) continue;
                    if (n >= lim) break;
                    n++;
                    r = '0;
                    r.count = 7'(n);
                    r.record_valid = 1;
                    r.key_low = key_lo[s];
                    r.key_high = key_hi[s];
                    r.last_seen = seen[s];
                    r.packets = pkts[s];
                    r.bytes_seen = byts[s];
                    pending.push_back(r);
                end
                exported += n;
                if (n == 0) begin
                    r = '0;
                    r.last = 1;
                    pending.push_back(r);
                end else begin
                    pending[pending.size()-1].last = 1;
                end
            end
            default: pending.push_back(r);
        endcase
    endfunction

    task report(string what, logic [127:0] got, logic [127:0] want);
        errors++;
        $display("MISMATCH result %0d %s: got %0h want %0h", results_seen, what, got, want);
    endtask

    task check_result(flow_result_t got);
        flow_result_t w;
        results_seen++;
        if (pending.size() == 0) begin
            report("unexpected result", 128'(got.last), '0);
            return;
        end
        w = pending.pop_front();
        if (got.status != w.status) report("status", got.status, w.status);
        if (got.is_new != w.is_new) report("is_new", got.is_new, w.is_new);
        if (got.count != w.count) report("count", got.count, w.count);
        if (got.record_valid != w.record_valid)
            report("record_valid", got.record_valid, w.record_valid);
        if (got.key_low != w.key_low) report("key_low", got.key_low, w.key_low);
        if (got.key_high != w.key_high) report("key_high", got.key_high, w.key_high);
        if (got.last_seen != w.last_seen) report("last_seen", got.last_seen, w.last_seen);
        if (got.packets != w.packets) report("packets", got.packets, w.packets);
        if (got.bytes_seen != w.bytes_seen) report("bytes", got.bytes_seen, w.bytes_seen);
        if (got.last != w.last) report("last", got.last, w.last);
    endtask
endclass

module flow_session_tracker_top_tb;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_wr_en = 0;
    logic [63:0] i_cfg_wr_data = '0;
    logic i_valid = 0;
    logic o_ready;
    logic [1:0] i_operation = '0;
    logic [63:0] i_key_low = '0;
    logic [39:0] i_key_high = '0;
    logic [15:0] i_packet_length = '0;
    logic [63:0] i_now_time = '0;
    logic [6:0] i_export_limit = '0;
    logic o_valid;
    logic i_ready = 0;
    logic o_status, o_is_new, o_record_valid, o_last;
    logic [6:0] o_count;
    logic [63:0] o_out_key_low, o_out_last_seen, o_out_packets, o_out_bytes;
    logic [39:0] o_out_key_high;

    flow_table_scoreboard flows = new();

    // Idle rates in percent; the receiver can also be held off outright.
    int send_idle_pct;
    int recv_idle_pct;
    int recv_hold_cycles;
    longint cycle_count;
    // Small pool of keys so that tracks often hit.
    logic [63:0] key_pool_lo[16];
    logic [39:0] key_pool_hi[16];
    logic [63:0] clock_now;

    always #2 i_clk = ~i_clk;

    flow_session_tracker_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_operation(i_operation), .i_key_low(i_key_low), .i_key_high(i_key_high),
        .i_packet_length(i_packet_length), .i_now_time(i_now_time),
        .i_export_limit(i_export_limit),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_status(o_status), .o_is_new(o_is_new), .o_count(o_count),
        .o_record_valid(o_record_valid), .o_out_key_low(o_out_key_low),
        .o_out_key_high(o_out_key_high), .o_out_last_seen(o_out_last_seen),
        .o_out_packets(o_out_packets), .o_out_bytes(o_out_bytes), .o_last(o_last)
    );

    // Generous ceiling: each item may scan all 64 slots, plus
    // up to 64 export results each behind long receiver stalls.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Results are sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            flows.check_result({o_status, o_is_new, o_count, o_record_valid,
                                o_out_key_low, o_out_key_high, o_out_last_seen,
                                o_out_packets, o_out_bytes, o_last});
    end

    // Receiver: ready changes at the falling edge, either held off for a
    // counted stretch or toggled at the current idle rate.
    always @(negedge i_clk) begin
        if (recv_hold_cycles > 0) begin
            recv_hold_cycles <= recv_hold_cycles - 1;
            i_ready <= 0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one item and hold it until accepted.
    task automatic send_item(logic [1:0] op, logic [63:0] klo, logic [39:0] khi,
                             logic [15:0] len, logic [63:0] now, logic [6:0] lim);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 0;
            @(negedge i_clk);
        end
        i_valid = 1;
        i_operation <= op;
        i_key_low <= klo;
        i_key_high <= khi;
        i_packet_length <= len;
        i_now_time <= now;
        i_export_limit <= lim;
        do @(posedge i_clk); while (!(o_ready && i_valid));
        flows.note_item(op, klo, khi, len, now, lim);
        @(negedge i_clk);
        i_valid = 0;
    endtask

    task automatic drain();
        while (flows.pending.size() != 0) @(negedge i_clk);
        // A track never leaves work behind its result; allow a full scan anyway.
        repeat (140) @(negedge i_clk);
    endtask

    task automatic write_timeout(logic [63:0] value);
        drain();
        i_cfg_wr_en <= 1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 0;
        flows.timeout = value;
    endtask

    task automatic track_key(int k, logic [15:0] len);
        send_item(fs_trk_pkg::OP_TRACK, key_pool_lo[k], key_pool_hi[k], len, clock_now,
                  '0);
    endtask

    // Mostly tracks on pooled keys with an advancing clock; sometimes sweeps,
    // exports, fresh random keys, clock jumps and the unused code.
    task automatic random_item();
        int pick;
        logic [1:0] op;
        pick = $urandom_range(99);
        clock_now += $urandom_range(20);
        if (pick < 3) clock_now = {$urandom, $urandom};
        if (pick < 65) begin
            track_key($urandom_range(15), 16'($urandom));
        end else if (pick < 75) begin
            send_item(fs_trk_pkg::OP_TRACK, {$urandom, $urandom},
                      $urandom_range(255) == 0 ? '1 : 40'({$urandom, $urandom}),
                      16'($urandom), clock_now, 7'($urandom));
        end else if (pick < 85) begin
            send_item(fs_trk_pkg::OP_SWEEP, {$urandom, $urandom},
                      40'({$urandom, $urandom}), 16'($urandom),
                      clock_now + $urandom_range(40), 7'($urandom));
        end else if (pick < 97) begin
            send_item(fs_trk_pkg::OP_EXPORT, {$urandom, $urandom},
                      40'({$urandom, $urandom}), 16'($urandom),
                      clock_now, 7'($urandom_range(127)));
        end else begin
            op = fs_trk_pkg::OP_UNUSED;
            send_item(op, {$urandom, $urandom}, 40'({$urandom, $urandom}),
                      16'($urandom), {$urandom, $urandom}, 7'($urandom));
        end
    endtask

    initial begin
        cycle_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold_cycles = 0;
        clock_now = 1;
        flows.clear_table();
        for (int k = 0; k < 16; k++) begin
            key_pool_lo[k] = {$urandom, $urandom};
            key_pool_hi[k] = 40'({$urandom, $urandom});
        end
        key_pool_lo[0] = '0;
        key_pool_hi[0] = '0;
        key_pool_lo[1] = '1;
        key_pool_hi[1] = '1;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: empty-table export and sweep, extreme keys and lengths,
        // a session seen at time zero, a wrapping clock, unknown code.
        send_item(fs_trk_pkg::OP_EXPORT, '0, '0, '0, 64'd5, 7'd64);
        send_item(fs_trk_pkg::OP_SWEEP, '0, '0, '0, '1, '0);
        send_item(fs_trk_pkg::OP_TRACK, key_pool_lo[0], key_pool_hi[0], '0, '0, '0);
        send_item(fs_trk_pkg::OP_TRACK, key_pool_lo[1], key_pool_hi[1], 16'hffff, '1, '1);
        send_item(fs_trk_pkg::OP_TRACK, key_pool_lo[1], key_pool_hi[1], 16'hffff, 64'd3,
                  '0);
        send_item(fs_trk_pkg::OP_TRACK, key_pool_lo[0], key_pool_hi[0], 16'd9, '0, '0);
        send_item(fs_trk_pkg::OP_EXPORT, '0, '0, '0, 64'd3, 7'd0);
        send_item(fs_trk_pkg::OP_EXPORT, '0, '0, '0, 64'd3, 7'd127);
        send_item(fs_trk_pkg::OP_UNUSED, '1, '1, '1, '1, '1);
        write_timeout(64'd1);
        send_item(fs_trk_pkg::OP_EXPORT, '0, '0, '0, 64'd10, 7'd64);
        send_item(fs_trk_pkg::OP_SWEEP, '0, '0, '0, 64'd10, '0);
        write_timeout('1);
        send_item(fs_trk_pkg::OP_SWEEP, '0, '0, '0, 64'd2, '0);
        write_timeout('0);

        // Fill the table past capacity to exercise the full status, then
        // export every session seen after time zero with the receiver held off so the block stalls.
        for (int i = 0; i < 66; i++)
            send_item(fs_trk_pkg::OP_TRACK, {$urandom, $urandom},
                      40'({$urandom, $urandom}), 16'($urandom), 64'd100 + i, '0);
        recv_hold_cycles = 600;
        send_item(fs_trk_pkg::OP_EXPORT, '0, '0, '0, 64'd200, 7'd64);
        send_item(fs_trk_pkg::OP_EXPORT, '0, '0, '0, 64'd200, 7'd3);
        send_item(fs_trk_pkg::OP_TRACK, key_pool_lo[2], key_pool_hi[2], 16'd1, 64'd201,
                  '0);
        // Sender pauses until all results are in, then the timeout clears every session but the one seen at time zero.
        write_timeout(64'd5);
        send_item(fs_trk_pkg::OP_SWEEP, '0, '0, '0, 64'd500, '0);
        clock_now = 600;

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 79 : 0;
            recv_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 13 : 0;
            write_timeout(phase == 0 ? 64'd30 : phase == 1 ? 64'd0 : 64'd60);
            for (int i = 0; i < 63; i++) random_item();
        end

        drain();
        $display("covered %0d results: %0d full-table misses, %0d sessions exported",
                 flows.results_seen, flows.full_hits, flows.exported);
        $display("timeouts 0, 1, 5, 30, 60 and all-ones; three idling phases");
        if (flows.errors == 0 && flows.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
